FILE: hdl/pattern_occurrence_range_counter_macros.svh
// Assertion helpers shared by the verification side of the project.
`ifndef PATTERN_OCCURRENCE_RANGE_COUNTER_MACROS_SVH
`define PATTERN_OCCURRENCE_RANGE_COUNTER_MACROS_SVH

// Same-cycle implication, muted while reset is applied.
`define POR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is applied.
`define POR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/por_pkg.sv
`default_nettype none

package por_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int TEXT_MAX_DEF    = 1024;
    localparam int QUEUE_DEPTH     = 2;

    localparam int OP_W      = 2;
    localparam int PIDX_W    = 4;
    localparam int WORD_W    = 32;
    localparam int POS_W     = 10;
    localparam int CNT_W     = 11;
    localparam int STATUS_W  = 2;
    localparam int LEN_CFG_W = 5;

    // Operation codes on the request channel
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Query status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CLAMP = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_APPEND,
        CMD_QUERY,
        CMD_CLEAR
    } cmd_kind_t;

    // Classified request handed from the front end to the execution side
    typedef struct packed {
        cmd_kind_t          kind;
        logic               pidx_ok;
        logic               left_gt_right;
        logic [PIDX_W-1:0]  pattern_index;
        logic [WORD_W-1:0]  word_value;
        logic [POS_W-1:0]   range_left;
        logic [POS_W-1:0]   range_right;
    } cmd_t;

endpackage

`default_nettype wire

FILE: hdl/por_ram.sv
`default_nettype none

module por_ram #(
    parameter int WIDTH = por_pkg::CNT_W,
    parameter int DEPTH = por_pkg::TEXT_MAX_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // hold read data between reads
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/por_front.sv
`default_nettype none

module por_front #(
    parameter int PATTERN_MAX = por_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [por_pkg::OP_W-1:0]    operation,
    input  wire logic [por_pkg::PIDX_W-1:0]  pattern_index,
    input  wire logic [por_pkg::WORD_W-1:0]  word_value,
    input  wire logic [por_pkg::POS_W-1:0]   range_left,
    input  wire logic [por_pkg::POS_W-1:0]   range_right,
    output logic                             push_valid,
    input  wire logic                        push_ready,
    output por_pkg::cmd_t                    cmd
);

    assign push_valid = in_valid;
    assign in_ready   = push_ready;

    always_comb
    begin
        unique case (operation)
            por_pkg::OP_LOAD:   cmd.kind = por_pkg::CMD_LOAD;
            por_pkg::OP_APPEND: cmd.kind = por_pkg::CMD_APPEND;
            por_pkg::OP_QUERY:  cmd.kind = por_pkg::CMD_QUERY;
            default:            cmd.kind = por_pkg::CMD_CLEAR;
        endcase
        // flag loads aimed past the pattern store; the execution side drops them
        cmd.pidx_ok       = (32'(pattern_index) < PATTERN_MAX);
        cmd.left_gt_right = (range_left > range_right);
        cmd.pattern_index = pattern_index;
        cmd.word_value    = word_value;
        cmd.range_left    = range_left;
        cmd.range_right   = range_right;
    end

endmodule

`default_nettype wire

FILE: hdl/por_queue.sv
`default_nettype none

module por_queue #(
    parameter int DEPTH = por_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire por_pkg::cmd_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output por_pkg::cmd_t      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    por_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           push, pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/por_back.sv
`default_nettype none

module por_back #(
    parameter int PATTERN_MAX = por_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = por_pkg::TEXT_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [por_pkg::LEN_CFG_W-1:0]  cfg_wdata,
    input  wire logic                           cmd_valid,
    output logic                                cmd_ready,
    input  wire por_pkg::cmd_t                  cmd,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [por_pkg::CNT_W-1:0]           match_count,
    output logic [por_pkg::STATUS_W-1:0]        query_status
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam int IW    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int TL_W  = $clog2(TEXT_MAX + 1);
    localparam int AW    = $clog2(TEXT_MAX);
    localparam int QW    = ((TL_W > por_pkg::POS_W) ? TL_W : por_pkg::POS_W) + 1;

    logic [por_pkg::WORD_W-1:0]    pattern_reg [PATTERN_MAX];
    logic [por_pkg::WORD_W-1:0]    window_reg  [PATTERN_MAX];
    logic [por_pkg::WORD_W-1:0]    window_next [PATTERN_MAX];
    logic [por_pkg::WORD_W-1:0]    shift_win   [PATTERN_MAX];
    logic [IW-1:0]                 sel_idx     [PATTERN_MAX];
    logic [TL_W-1:0]               text_len_reg, text_len_next, new_len;
    logic [por_pkg::CNT_W-1:0]     total_reg, total_next, total_inc;
    logic [por_pkg::LEN_CFG_W-1:0] plen_reg;
    logic [LEN_W-1:0]              eff_len;

    logic                          pend_valid_reg, pend_valid_next;
    logic [por_pkg::STATUS_W-1:0]  pend_status_reg, pend_status_next;
    logic                          pend_use_reg, pend_use_next;
    logic                          pend_lo_zero_reg, pend_lo_zero_next;

    logic                          out_valid_reg, out_valid_next;
    logic [por_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [por_pkg::STATUS_W-1:0]  status_reg, status_next;

    logic                          full, hit, fire, can_move;
    logic                          ram_we, ram_re;
    logic [AW-1:0]                 hi_addr, lo_addr;
    logic [por_pkg::CNT_W-1:0]     rdata_hi, rdata_lo;

    logic [QW-1:0]                 left_q, right_q, tl_q, n_q, rr_q, lo_q;
    logic [por_pkg::STATUS_W-1:0]  q_status;
    logic                          q_use, q_lo_zero;

    // pattern length in use: zero counts as one, clamp to the store size
    always_comb
    begin
        if (plen_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(plen_reg) > PATTERN_MAX)
        begin
            eff_len = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            eff_len = LEN_W'(plen_reg);
        end
    end

    // append path: shifted window and parallel compare
    assign full      = (text_len_reg == TL_W'(TEXT_MAX));
    assign new_len   = text_len_reg + 1'b1;
    assign total_inc = hit ? total_reg + 1'b1 : total_reg;

    always_comb
    begin
        shift_win[0] = cmd.word_value;
        for (int k = 1; k < PATTERN_MAX; k++)
        begin
            shift_win[k] = window_reg[k-1];
        end
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            sel_idx[k] = IW'(32'(eff_len) - 32'd1 - 32'(k));
        end
    end

    always_comb
    begin
        hit = (32'(new_len) >= 32'(eff_len));
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (32'(k) < 32'(eff_len) && pattern_reg[sel_idx[k]] != shift_win[k])
            begin
                hit = 1'b0;
            end
        end
    end

    // query path: clamp, range checks, two prefix addresses
    assign left_q  = QW'(cmd.range_left);
    assign right_q = QW'(cmd.range_right);
    assign tl_q    = QW'(text_len_reg);
    assign n_q     = QW'(eff_len);
    assign lo_q    = left_q + n_q - QW'(2);
    assign hi_addr = rr_q[AW-1:0];
    assign lo_addr = lo_q[AW-1:0];
    assign q_lo_zero = (left_q == '0) && (n_q == QW'(1));

    always_comb
    begin
        q_status = por_pkg::ST_OK;
        q_use    = 1'b0;
        rr_q     = right_q;
        if (cmd.left_gt_right)
        begin
            q_status = por_pkg::ST_ORDER;
        end
        else
        begin
            if (right_q >= tl_q)
            begin
                q_status = por_pkg::ST_CLAMP;
                rr_q     = tl_q - 1'b1;
            end
            if (tl_q != '0 && rr_q >= left_q && (rr_q - left_q + 1'b1) >= n_q)
            begin
                q_use = 1'b1;
            end
        end
    end

    // a query may issue once its read result has a place to go
    assign can_move  = !out_valid_reg || out_ready;
    assign cmd_ready = (cmd.kind != por_pkg::CMD_QUERY) || !pend_valid_reg || can_move;
    assign fire      = cmd_valid && cmd_ready;
    assign ram_we    = fire && (cmd.kind == por_pkg::CMD_APPEND) && !full;
    assign ram_re    = fire && (cmd.kind == por_pkg::CMD_QUERY);

    por_ram #(
        .WIDTH (por_pkg::CNT_W),
        .DEPTH (TEXT_MAX)
    ) u_prefix (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (text_len_reg[AW-1:0]),
        .wdata   (total_inc),
        .re      (ram_re),
        .raddr_a (hi_addr),
        .raddr_b (lo_addr),
        .rdata_a (rdata_hi),
        .rdata_b (rdata_lo)
    );

    always_comb
    begin
        text_len_next     = text_len_reg;
        total_next        = total_reg;
        window_next       = window_reg;
        pend_valid_next   = pend_valid_reg;
        pend_status_next  = pend_status_reg;
        pend_use_next     = pend_use_reg;
        pend_lo_zero_next = pend_lo_zero_reg;
        out_valid_next    = out_valid_reg;
        count_next        = count_reg;
        status_next       = status_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        // finish the pending query whose prefix reads have returned
        if (pend_valid_reg && can_move)
        begin
            pend_valid_next = 1'b0;
            out_valid_next  = 1'b1;
            status_next     = pend_status_reg;
            if (pend_use_reg)
            begin
                count_next = pend_lo_zero_reg ? rdata_hi : rdata_hi - rdata_lo;
            end
            else
            begin
                count_next = '0;
            end
        end

        if (fire)
        begin
            unique case (cmd.kind)
                por_pkg::CMD_APPEND:
                begin
                    if (!full)
                    begin
                        window_next   = shift_win;
                        text_len_next = new_len;
                        total_next    = total_inc;
                    end
                end
                por_pkg::CMD_QUERY:
                begin
                    pend_valid_next   = 1'b1;
                    pend_status_next  = q_status;
                    pend_use_next     = q_use;
                    pend_lo_zero_next = q_lo_zero;
                end
                por_pkg::CMD_CLEAR:
                begin
                    text_len_next = '0;
                    total_next    = '0;
                    for (int k = 0; k < PATTERN_MAX; k++)
                    begin
                        window_next[k] = '0;
                    end
                end
                default:
                begin
                    // pattern loads go to the store below
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_len_reg     <= '0;
            total_reg        <= '0;
            plen_reg         <= por_pkg::LEN_CFG_W'(1);
            pend_valid_reg   <= 1'b0;
            pend_status_reg  <= por_pkg::ST_OK;
            pend_use_reg     <= 1'b0;
            pend_lo_zero_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            count_reg        <= '0;
            status_reg       <= por_pkg::ST_OK;
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                window_reg[k] <= '0;
            end
        end
        else
        begin
            text_len_reg     <= text_len_next;
            total_reg        <= total_next;
            pend_valid_reg   <= pend_valid_next;
            pend_status_reg  <= pend_status_next;
            pend_use_reg     <= pend_use_next;
            pend_lo_zero_reg <= pend_lo_zero_next;
            out_valid_reg    <= out_valid_next;
            count_reg        <= count_next;
            status_reg       <= status_next;
            window_reg       <= window_next;
            if (cfg_we)
            begin
                plen_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if (fire && cmd.kind == por_pkg::CMD_LOAD && cmd.pidx_ok &&
                32'(cmd.pattern_index) == 32'(k))
            begin
                pattern_reg[k] <= cmd.word_value;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign match_count  = count_reg;
    assign query_status = status_reg;

endmodule

`default_nettype wire

FILE: hdl/pattern_occurrence_range_counter.sv
// Channel    Handshake             Payload
// request    in_valid/in_ready     operation, pattern_index, word_value,
//                                  range_left, range_right
// result     out_valid/out_ready   match_count, query_status
// config     cfg_we                cfg_wdata (pattern length)
//
// One request per cycle is taken into a two-entry queue while it has room;
// the execution side retires one per cycle from it unless a query is held.
// A query reads the prefix count memory at two addresses through its two
// read ports at once. A request passes the queue entry, then the memory's
// read registers, then the result registers; a query waits with its read
// data until the result registers are free or being read out.
// Reset (rst_n, async, active low) empties the queue and the text, sets the
// pattern length to one; the prefix memory needs no clearing pass.
// While a result is held, one more query may take its prefix reads; the next
// query then waits at the head of the queue and holds up everything behind it.
`default_nettype none

module pattern_occurrence_range_counter #(
    parameter int PATTERN_MAX = por_pkg::PATTERN_MAX_DEF,
    parameter int TEXT_MAX    = por_pkg::TEXT_MAX_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [por_pkg::LEN_CFG_W-1:0]  cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [por_pkg::OP_W-1:0]       operation,
    input  wire logic [por_pkg::PIDX_W-1:0]     pattern_index,
    input  wire logic [por_pkg::WORD_W-1:0]     word_value,
    input  wire logic [por_pkg::POS_W-1:0]      range_left,
    input  wire logic [por_pkg::POS_W-1:0]      range_right,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [por_pkg::CNT_W-1:0]           match_count,
    output logic [por_pkg::STATUS_W-1:0]        query_status
);

    // front end -> queue
    logic          push_valid, push_ready;
    por_pkg::cmd_t push_cmd;

    // queue -> execution side
    logic          pop_valid, pop_ready;
    por_pkg::cmd_t pop_cmd;

    // Classify each request: decode the operation, flag loads past the store
    // and queries with swapped bounds.
    por_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .pattern_index (pattern_index),
        .word_value    (word_value),
        .range_left    (range_left),
        .range_right   (range_right),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .cmd           (push_cmd)
    );

    // Decouple intake from execution so a stalled result does not block
    // the request channel right away.
    por_queue #(
        .DEPTH (por_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    // Execute: pattern store, text window compare, prefix counts, queries.
    por_back #(
        .PATTERN_MAX (PATTERN_MAX),
        .TEXT_MAX    (TEXT_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd_valid    (pop_valid),
        .cmd_ready    (pop_ready),
        .cmd          (pop_cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .match_count  (match_count),
        .query_status (query_status)
    );

endmodule

`default_nettype wire

FILE: hdl/por_checker.sv
`include "pattern_occurrence_range_counter_macros.svh"
`default_nettype none

module por_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [por_pkg::OP_W-1:0]      operation,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [por_pkg::CNT_W-1:0]     match_count,
    input wire logic [por_pkg::STATUS_W-1:0]  query_status
);

    logic [3:0] outstanding_reg, outstanding_next;
    logic       query_in, result_out;

    assign query_in   = in_valid && in_ready && (operation == por_pkg::OP_QUERY);
    assign result_out = out_valid && out_ready;

    // track queries taken but not yet answered
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (query_in && !result_out)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (result_out && !query_in)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    `POR_ASSERT_NXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(match_count) && $stable(query_status), "stalled result changed")
    `POR_ASSERT_IMP(a_order_zero, clk, rst_n, out_valid && query_status == por_pkg::ST_ORDER, match_count == '0, "swapped bounds gave a nonzero count")
    `POR_ASSERT_IMP(a_no_extra_result, clk, rst_n, out_valid, outstanding_reg != '0, "result without an open query")
    `POR_ASSERT_IMP(a_bounded_backlog, clk, rst_n, 1'b1, outstanding_reg <= 4'(por_pkg::QUEUE_DEPTH + 2), "more open queries than the buffering holds")

endmodule

bind pattern_occurrence_range_counter por_checker u_por_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .match_count  (match_count),
    .query_status (query_status)
);

`default_nettype wire
